// File: design/cfp_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the crc byte update for the frame parser
// no dependencies

package cfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [7:0] END_FIRST_RST   = 8'h0D;
    localparam logic [7:0] END_SECOND_RST  = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_END_FIRST   = 2'd2,
        CFG_END_SECOND  = 2'd3
    } t_cfg_idx;

    // handoff of a checked frame from the parser to the emitter
    typedef struct packed {
        logic             start;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
    } t_emit_req;

    // payload store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/cfp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: received bytes, results, register writes
// depends on cfp_pkg

interface cfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
    import cfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [7:0]        command;
    logic [LEN_W-1:0]  pay_len;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        payload_byte;
    logic              has_payload;
    logic              last;

    modport source (output valid, output command, output pay_len,
                    output byte_index, output payload_byte, output has_payload,
                    output last, input ready);
    modport sink   (input valid, input command, input pay_len,
                    input byte_index, input payload_byte, input has_payload,
                    input last, output ready);
endinterface

interface cfp_cfg_if;
    import cfp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// File: design/crc_checked_frame_parser_top.sv
`timescale 1ns / 1ps
// Frame parser with CRC-16/MODBUS check.
// Channels: i_rx takes one received byte per transfer, o_res gives one result
// per payload byte of a checked frame (a single result for an empty frame),
// i_cfg writes the sync and end byte registers (index 0..3).
// While a frame is being received one byte is taken every cycle that the
// source offers one; the crc is updated in the same cycle as the byte is taken.
// Payload bytes go into a 64-entry single-port-write store. After the second
// end byte of a checked frame is taken, the first payload result passes the
// parser's request register, the emitter's busy flag, the store read and the
// output register; the rest follow one per cycle while o_res is ready, set by
// the store read. During emission i_rx.ready is low until the last result is
// in the output register. A stall on o_res holds the output register and the
// store read; nothing is lost. Configuration writes are always taken.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for the first
// sync byte, restores the register defaults and drops any pending result;
// the payload store is not cleared.
// Depends on cfp_pkg, cfp_if, cfp_ram, cfp_parser, cfp_emitter.

module crc_checked_frame_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfp_rx_if.sink    i_rx,
    cfp_cfg_if.sink   i_cfg,
    cfp_res_if.source o_res
);
    import cfp_pkg::*;

    t_store_wr         wr;
    t_emit_req         req;
    logic              busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    cfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (i_cfg),
        .i_busy  (busy),
        .o_wr    (wr),
        .o_req   (req)
    );

    cfp_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cfp_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (o_res)
    );

endmodule

// File: design/cfp_ram.sv
`timescale 1ns / 1ps
// payload store: one write port, one read port with registered read data
// depends on cfp_pkg

module cfp_ram (
    input  logic                       i_clk,
    input  cfp_pkg::t_store_wr         i_wr,
    input  logic                       i_rd_en,
    input  logic [cfp_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import cfp_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/cfp_parser.sv
`timescale 1ns / 1ps
// frame recognizer: sync/length/command/payload/crc/end, running crc,
// configuration registers, writes payload into the store; depends on cfp_pkg, cfp_if

module cfp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfp_rx_if.sink             i_rx,
    cfp_cfg_if.sink            i_cfg,
    input  logic               i_busy,
    output cfp_pkg::t_store_wr o_wr,
    output cfp_pkg::t_emit_req o_req
);
    import cfp_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC0, PH_SYNC1, PH_LEN, PH_CMD, PH_DATA,
        PH_CHK0, PH_CHK1, PH_END0, PH_END1
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_chk, n_chk;
    logic [7:0]       r_sync_first, r_sync_second, r_end_first, r_end_second;
    t_emit_req        r_req, n_req;

    logic        take;
    logic        restart;
    logic [7:0]  b;
    logic [15:0] crc_next;
    logic [15:0] crc_sync;
    logic [LEN_W-1:0] fill_inc;

    // no bytes while the emitter reads the store
    assign i_rx.ready = !i_busy && !r_req.start;
    assign i_cfg.ready = 1'b1;
    assign take = i_rx.valid && i_rx.ready;
    assign b = i_rx.rx_byte;
    assign fill_inc = r_fill + LEN_W'(1);
    assign crc_next = crc_feed(r_crc, b);
    // crc of a byte that opens a new frame
    assign crc_sync = crc_feed(CRC_INIT, b);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_fill  = r_fill;
        n_cmd   = r_cmd;
        n_crc   = r_crc;
        n_chk   = r_chk;
        n_req   = '0;
        restart = 1'b0;
        o_wr    = '0;
        o_wr.addr = r_fill[ADDR_W-1:0];
        o_wr.data = b;

        if (take) begin
            case (r_phase)
                PH_SYNC0: restart = 1'b1;
                PH_SYNC1: begin
                    if (b == r_sync_second) begin
                        n_crc   = crc_next;
                        n_phase = PH_LEN;
                    end else begin
                        restart = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (b <= 8'(MAX_PAYLOAD)) begin
                        n_len   = b[LEN_W-1:0];
                        n_fill  = '0;
                        n_crc   = crc_next;
                        n_phase = PH_CMD;
                    end else begin
                        restart = 1'b1;
                    end
                end
                PH_CMD: begin
                    n_cmd   = b;
                    n_crc   = crc_next;
                    n_phase = (r_len == '0) ? PH_CHK0 : PH_DATA;
                end
                PH_DATA: begin
                    o_wr.en = 1'b1;
                    n_crc   = crc_next;
                    n_fill  = fill_inc;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_CHK0;
                    end
                end
                PH_CHK0: begin
                    n_chk   = {8'h00, b};
                    n_phase = PH_CHK1;
                end
                PH_CHK1: begin
                    n_chk   = {b, r_chk[7:0]};
                    n_phase = PH_END0;
                end
                PH_END0: begin
                    if (b == r_end_first) begin
                        n_phase = PH_END1;
                    end else begin
                        restart = 1'b1;
                    end
                end
                PH_END1: begin
                    if (b != r_end_second || r_crc != r_chk) begin
                        restart = 1'b1;
                    end else begin
                        n_req.start   = 1'b1;
                        n_req.command = r_cmd;
                        n_req.length  = r_len;
                        n_phase = PH_SYNC0;
                        n_len   = '0;
                        n_fill  = '0;
                        n_cmd   = '0;
                        n_crc   = CRC_INIT;
                        n_chk   = '0;
                    end
                end
                default: restart = 1'b1;
            endcase

            // back to idle; the offending byte may open a new frame
            if (restart) begin
                n_phase = PH_SYNC0;
                n_len   = '0;
                n_fill  = '0;
                n_cmd   = '0;
                n_crc   = CRC_INIT;
                n_chk   = '0;
                if (b == r_sync_first) begin
                    n_crc   = crc_sync;
                    n_phase = PH_SYNC1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC0;
            r_len         <= '0;
            r_fill        <= '0;
            r_cmd         <= '0;
            r_crc         <= CRC_INIT;
            r_chk         <= '0;
            r_req         <= '0;
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_end_first   <= END_FIRST_RST;
            r_end_second  <= END_SECOND_RST;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_cmd   <= n_cmd;
            r_crc   <= n_crc;
            r_chk   <= n_chk;
            r_req   <= n_req;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.idx))
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg.data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg.data;
                    CFG_END_FIRST:   r_end_first   <= i_cfg.data;
                    CFG_END_SECOND:  r_end_second  <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    assign o_req = r_req;

endmodule

// File: design/cfp_emitter.sv
`timescale 1ns / 1ps
// result emitter: walks the payload store of a checked frame, one read per
// cycle while o_res is not stalled, into an output register; depends on cfp_pkg, cfp_if

module cfp_emitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfp_pkg::t_emit_req         i_req,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [cfp_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    cfp_res_if.source                  o_res
);
    import cfp_pkg::*;

    logic              r_busy;
    logic              r_empty;
    logic [7:0]        r_cmd;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_rd_cnt;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_idx;
    logic              r_pend_last;

    logic              r_out_valid;
    logic [7:0]        r_out_cmd;
    logic [LEN_W-1:0]  r_out_len;
    logic [ADDR_W-1:0] r_out_idx;
    logic [7:0]        r_out_byte;
    logic              r_out_has;
    logic              r_out_last;

    logic out_free, load_data, load_empty, rd_left, rd_en;
    logic [LEN_W-1:0] rd_cnt_inc;

    assign out_free   = !r_out_valid || o_res.ready;
    // r_pend: registered store data not yet moved to the output
    assign load_data  = r_pend && out_free;
    assign load_empty = r_empty && out_free;
    assign rd_left    = r_busy && !r_empty && (r_rd_cnt != r_len);
    assign rd_en      = rd_left && (!r_pend || load_data);
    assign rd_cnt_inc = r_rd_cnt + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_empty     <= 1'b0;
            r_rd_cnt    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cmd    <= i_req.command;
                r_len    <= i_req.length;
                r_rd_cnt <= '0;
                r_empty  <= (i_req.length == '0);
            end

            if (rd_en) begin
                r_pend      <= 1'b1;
                r_pend_idx  <= r_rd_cnt[ADDR_W-1:0];
                r_pend_last <= (rd_cnt_inc == r_len);
                r_rd_cnt    <= rd_cnt_inc;
            end else if (load_data) begin
                r_pend <= 1'b0;
            end

            if (load_data) begin
                r_out_valid <= 1'b1;
                r_out_cmd   <= r_cmd;
                r_out_len   <= r_len;
                r_out_idx   <= r_pend_idx;
                r_out_byte  <= i_rd_data;
                r_out_has   <= 1'b1;
                r_out_last  <= r_pend_last;
                if (r_pend_last) begin
                    r_busy <= 1'b0;
                end
            end else if (load_empty) begin
                r_out_valid <= 1'b1;
                r_out_cmd   <= r_cmd;
                r_out_len   <= '0;
                r_out_idx   <= '0;
                r_out_byte  <= '0;
                r_out_has   <= 1'b0;
                r_out_last  <= 1'b1;
                r_empty     <= 1'b0;
                r_busy      <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_en   = rd_en;
    assign o_rd_addr = r_rd_cnt[ADDR_W-1:0];

    assign o_res.valid        = r_out_valid;
    assign o_res.command      = r_out_cmd;
    assign o_res.pay_len      = r_out_len;
    assign o_res.byte_index   = r_out_idx;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.has_payload  = r_out_has;
    assign o_res.last         = r_out_last;

endmodule
